@@ design/mrbq_pkg.sv @@
// ----------------------------------------------------------------------------
// Broadcast queue package
// Shared constants, command and status codes, controller states and the
// result record of the multi-reader broadcast queue.
// ----------------------------------------------------------------------------
package mrbq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int READERS_DEF = 4;
	localparam int DATA_W_DEF  = 32;

	localparam logic [31:0] MAX_WAIT_RST = 32'd1000;
	localparam logic [31:0] HOLDOFF_RST  = 32'd1000;

	// Command codes carried by the command field.
	localparam logic [2:0] CMD_PUSH        = 3'd0;
	localparam logic [2:0] CMD_SUBSCRIBE   = 3'd1;
	localparam logic [2:0] CMD_PEEK        = 3'd2;
	localparam logic [2:0] CMD_POP         = 3'd3;
	localparam logic [2:0] CMD_UNSUBSCRIBE = 3'd4;

	// Status codes returned with every result.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_READERS = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_EMPTY      = 3'd3;
	localparam logic [2:0] ST_BAD_READER = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_MAX_WAIT = 1'b0;
	localparam logic CFG_HOLDOFF  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_SCAN,
		S_DROP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] payload_out;
		logic [31:0] entry_index;
		logic        head_advanced;
		logic [4:0]  dropped_count;
		logic        backlogged;
	} res_t;

endpackage

@@ design/mrbq_if.sv @@
// ----------------------------------------------------------------------------
// Broadcast queue channels
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface mrbq_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [1:0]  reader;
	logic [31:0] payload;
	logic [31:0] now;

	modport source (output valid, command, reader, payload, now, input ready);
	modport sink (input valid, command, reader, payload, now, output ready);
endinterface

interface mrbq_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] payload_out;
	logic [31:0] entry_index;
	logic        head_advanced;
	logic [4:0]  dropped_count;
	logic        backlogged;

	modport source (output valid, status, payload_out, entry_index, head_advanced,
		dropped_count, backlogged, input ready);
	modport sink (input valid, status, payload_out, entry_index, head_advanced,
		dropped_count, backlogged, output ready);
endinterface

@@ design/mrbq_ram.sv @@
// ----------------------------------------------------------------------------
// Broadcast queue RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mrbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/multi_reader_broadcast_queue.sv @@
// ----------------------------------------------------------------------------
// Multi-reader broadcast queue
// Ring of entries shared by several readers, each with its own read position.
// ----------------------------------------------------------------------------
// Every command beat produces exactly one result beat. Push, subscribe, peek
// and pop pass through the accept, memory read, execute and result states;
// unsubscribe adds a scan and a drop state after execute, because the new
// oldest entry is found by walking the reader positions one reader per cycle
// to find the smallest distance from the head. Entry data and entry times
// live in two single-port-read RAMs with registered read data; the time RAM
// is read only at the head slot. A backlog rewrite does not sweep the RAM:
// it records one override time together with the number of leading entries
// it covers, and that count shrinks as entries are freed. A new command is
// accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_queue #(
	parameter int DEPTH   = mrbq_pkg::DEPTH_DEF,
	parameter int READERS = mrbq_pkg::READERS_DEF,
	parameter int DATA_W  = mrbq_pkg::DATA_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mrbq_cmd_if.sink    cmd,
	mrbq_res_if.source  res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

	mrbq_pkg::state_t state_q, state_d;

	// Latched command beat.
	logic [2:0]        cmd_q;
	logic [5:0]        rdr_q;
	logic [DATA_W-1:0] pay_q;
	logic [31:0]       now_q;

	logic [31:0] max_wait_q, holdoff_q;

	// Queue bookkeeping.
	logic [31:0]   head_seq_q, next_seq_q;
	logic [SW-1:0] head_slot_q, tail_slot_q;
	logic [READERS-1:0] active_q;
	logic [31:0]   pos_q   [READERS];
	logic [SW-1:0] rslot_q [READERS];

	// Backlog override: the first ovr_left_q entries carry ovr_time_q.
	logic [31:0]   ovr_time_q;
	logic [CW-1:0] ovr_left_q;

	// Unsubscribe scan.
	logic [RW-1:0] scan_idx_q;
	logic [CW-1:0] min_q;

	mrbq_pkg::res_t res_q, out_q;
	logic           out_valid_q;

	logic [DATA_W-1:0] data_rdata;
	logic [31:0]       time_rdata;

	// Execute-stage decode.
	logic [RW-1:0] rsel;
	logic          rdr_ok, any_act, r_act, has_entry, needed_other, full, back;
	logic          push_ok, sub_ok, peek_ok, pop_ok, unsub_ok, use_cmd;
	logic [31:0]   count, pos_r, head_time;
	logic [2:0]    status_c;
	logic [SW-1:0] tail_inc, head_inc, rslot_inc;
	logic [SW+1:0] drop_sum;
	logic [SW-1:0] drop_slot;
	logic [CW-1:0] scan_dist;
	logic          ram_we, out_load;

	assign rsel    = rdr_q[RW-1:0];
	assign rdr_ok  = 32'(rdr_q) < 32'(READERS);
	assign any_act = |active_q;
	assign r_act   = active_q[rsel];
	assign count   = next_seq_q - head_seq_q;
	assign full    = count >= 32'(DEPTH);
	assign pos_r   = pos_q[rsel];
	assign has_entry = (pos_r - head_seq_q) < count;

	assign head_time = (ovr_left_q != '0) ? ovr_time_q : time_rdata;
	assign back      = (count != 32'd0) && ((now_q - head_time) > max_wait_q);

	assign tail_inc  = (tail_slot_q == SW'(DEPTH - 1)) ? '0 : tail_slot_q + 1'b1;
	assign head_inc  = (head_slot_q == SW'(DEPTH - 1)) ? '0 : head_slot_q + 1'b1;
	assign rslot_inc = (rslot_q[rsel] == SW'(DEPTH - 1)) ? '0 : rslot_q[rsel] + 1'b1;

	assign drop_sum  = (SW+2)'(head_slot_q) + (SW+2)'(min_q);
	assign drop_slot = (drop_sum >= (SW+2)'(DEPTH)) ? SW'(drop_sum - (SW+2)'(DEPTH))
		: SW'(drop_sum);
	assign scan_dist = CW'(pos_q[scan_idx_q] - head_seq_q);

	always_comb begin
		needed_other = 1'b0;
		for (int i = 0; i < READERS; i++) begin
			if (active_q[i] && (RW'(i) != rsel) && (pos_q[i] == pos_r)) begin
				needed_other = 1'b1;
			end
		end
	end

	always_comb begin
		use_cmd  = (cmd_q == mrbq_pkg::CMD_PEEK) || (cmd_q == mrbq_pkg::CMD_POP)
			|| (cmd_q == mrbq_pkg::CMD_UNSUBSCRIBE);
		push_ok  = (cmd_q == mrbq_pkg::CMD_PUSH) && any_act && !full;
		sub_ok   = (cmd_q == mrbq_pkg::CMD_SUBSCRIBE) && rdr_ok && !r_act;
		peek_ok  = (cmd_q == mrbq_pkg::CMD_PEEK) && rdr_ok && r_act && has_entry;
		pop_ok   = (cmd_q == mrbq_pkg::CMD_POP) && rdr_ok && r_act && has_entry;
		unsub_ok = (cmd_q == mrbq_pkg::CMD_UNSUBSCRIBE) && rdr_ok && r_act;
		if (cmd_q == mrbq_pkg::CMD_PUSH) begin
			if (!any_act) begin
				status_c = mrbq_pkg::ST_NO_READERS;
			end else if (full) begin
				status_c = mrbq_pkg::ST_FULL;
			end else begin
				status_c = mrbq_pkg::ST_OK;
			end
		end else if (!rdr_ok) begin
			status_c = mrbq_pkg::ST_BAD_READER;
		end else if (cmd_q == mrbq_pkg::CMD_SUBSCRIBE) begin
			status_c = r_act ? mrbq_pkg::ST_BAD_READER : mrbq_pkg::ST_OK;
		end else if (!use_cmd || !r_act) begin
			status_c = mrbq_pkg::ST_BAD_READER;
		end else if ((cmd_q != mrbq_pkg::CMD_UNSUBSCRIBE) && !has_entry) begin
			status_c = mrbq_pkg::ST_EMPTY;
		end else begin
			status_c = mrbq_pkg::ST_OK;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrbq_pkg::S_IDLE: begin
				if (cmd.valid) begin
					state_d = mrbq_pkg::S_READ;
				end
			end
			mrbq_pkg::S_READ: state_d = mrbq_pkg::S_EXEC;
			mrbq_pkg::S_EXEC: state_d = unsub_ok ? mrbq_pkg::S_SCAN : mrbq_pkg::S_FIN;
			mrbq_pkg::S_SCAN: begin
				if (scan_idx_q == RW'(READERS - 1)) begin
					state_d = mrbq_pkg::S_DROP;
				end
			end
			mrbq_pkg::S_DROP: state_d = mrbq_pkg::S_FIN;
			mrbq_pkg::S_FIN: begin
				if (!out_valid_q || res.ready) begin
					state_d = mrbq_pkg::S_IDLE;
				end
			end
			default: state_d = mrbq_pkg::S_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		cmd.ready = (state_q == mrbq_pkg::S_IDLE);
		ram_we    = (state_q == mrbq_pkg::S_EXEC) && push_ok;
		out_load  = (state_q == mrbq_pkg::S_FIN) && (!out_valid_q || res.ready);
	end

	mrbq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_slot_q),
		.wdata (pay_q),
		.raddr (rslot_q[rsel]),
		.rdata (data_rdata)
	);

	mrbq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_slot_q),
		.wdata (now_q),
		.raddr (head_slot_q),
		.rdata (time_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrbq_pkg::S_IDLE;
			max_wait_q  <= mrbq_pkg::MAX_WAIT_RST;
			holdoff_q   <= mrbq_pkg::HOLDOFF_RST;
			head_seq_q  <= '0;
			next_seq_q  <= '0;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			active_q    <= '0;
			ovr_left_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < READERS; i++) begin
				pos_q[i]   <= '0;
				rslot_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == mrbq_pkg::CFG_MAX_WAIT) begin
					max_wait_q <= cfg_wdata;
				end else begin
					holdoff_q <= cfg_wdata;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mrbq_pkg::S_EXEC: begin
					if (push_ok) begin
						next_seq_q  <= next_seq_q + 32'd1;
						tail_slot_q <= tail_inc;
						if (back) begin
							ovr_left_q <= CW'(count + 32'd1);
						end
					end
					if (sub_ok) begin
						active_q[rsel] <= 1'b1;
						pos_q[rsel]    <= next_seq_q;
						rslot_q[rsel]  <= tail_slot_q;
					end
					if (pop_ok) begin
						pos_q[rsel]   <= pos_r + 32'd1;
						rslot_q[rsel] <= rslot_inc;
						if ((pos_r == head_seq_q) && !needed_other) begin
							head_seq_q  <= head_seq_q + 32'd1;
							head_slot_q <= head_inc;
							if (ovr_left_q != '0) begin
								ovr_left_q <= ovr_left_q - 1'b1;
							end
						end
					end
					if (unsub_ok) begin
						active_q[rsel] <= 1'b0;
					end
				end
				mrbq_pkg::S_DROP: begin
					head_seq_q  <= head_seq_q + 32'(min_q);
					head_slot_q <= drop_slot;
					ovr_left_q  <= (ovr_left_q > min_q) ? ovr_left_q - min_q : '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.command;
			rdr_q <= 6'(cmd.reader);
			pay_q <= DATA_W'(cmd.payload);
			now_q <= cmd.now;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			mrbq_pkg::S_EXEC: begin
				res_q.status        <= status_c;
				res_q.payload_out   <= peek_ok ? 32'(data_rdata) : 32'd0;
				res_q.entry_index   <= (peek_ok ? pos_r : 32'd0)
					| (push_ok ? next_seq_q : 32'd0);
				res_q.head_advanced <= pop_ok && (pos_r == head_seq_q) && !needed_other;
				res_q.dropped_count <= '0;
				res_q.backlogged    <= push_ok && back;
				if (push_ok && back) begin
					ovr_time_q <= now_q + holdoff_q;
				end
				scan_idx_q <= '0;
				min_q      <= CW'(count);
			end
			mrbq_pkg::S_SCAN: begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (active_q[scan_idx_q] && (scan_dist < min_q)) begin
					min_q <= scan_dist;
				end
			end
			mrbq_pkg::S_DROP: begin
				res_q.dropped_count <= 5'(min_q);
			end
			default: begin
			end
		endcase
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.payload_out   = out_q.payload_out;
	assign res.entry_index   = out_q.entry_index;
	assign res.head_advanced = out_q.head_advanced;
	assign res.dropped_count = out_q.dropped_count;
	assign res.backlogged    = out_q.backlogged;

	// The ring never holds more than DEPTH entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_seq_q - head_seq_q) <= 32'(DEPTH))
		else $error("ring holds more entries than its depth");

	// The backlog override never covers more entries than are stored.
	a_override_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ovr_left_q) <= (next_seq_q - head_seq_q))
		else $error("backlog override covers freed entries");

	// A result beat only appears after the result stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mrbq_pkg::S_FIN))
		else $error("result beat raised outside the result stage");

	// The execute stage always follows a memory read cycle.
	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrbq_pkg::S_EXEC) |-> $past(state_q == mrbq_pkg::S_READ))
		else $error("execute stage entered without memory read");

endmodule
